// ===== design/m3i_pkg.sv =====
package m3i_pkg;

    localparam int ELEM_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    // exact widths of the intermediate values
    localparam int PROD_W  = 2 * ELEM_WIDTH;
    localparam int COF_W   = PROD_W + 1;
    localparam int CMAG_W  = PROD_W;
    localparam int DMAG_W  = 3 * ELEM_WIDTH;
    localparam int DET_W   = DMAG_W + 1;
    localparam int NUM_W   = CMAG_W + 2 * FRAC_BITS;
    localparam int QBITS   = ELEM_WIDTH + 1;
    localparam int HI_W    = NUM_W - QBITS;
    localparam int CMP_W   = ((HI_W > DMAG_W) ? HI_W : DMAG_W) + 1;

    // pipeline depths
    localparam int FRONT_STAGES = 7;
    localparam int LANE_STAGES  = QBITS + 1;
    localparam int PIPE_STAGES  = FRONT_STAGES + LANE_STAGES + 1;
    localparam int N_ELEM       = 9;

    typedef logic signed [ELEM_WIDTH-1:0] elem_t;
    typedef logic signed [COF_W-1:0]      cof_t;
    typedef logic signed [DET_W-1:0]      det_t;

    typedef struct packed {
        logic             neg;
        logic             ovf;
        logic [QBITS-1:0] quo;
    } lane_res_t;

    typedef struct packed {
        logic  clip;
        elem_t val;
    } sat_t;

    function automatic logic [ELEM_WIDTH-1:0] elem_mag(input elem_t x);
        logic [ELEM_WIDTH-1:0] u;
        u = x;
        return x[ELEM_WIDTH-1] ? (~u + 1'b1) : u;
    endfunction

    function automatic logic [CMAG_W-1:0] cof_mag(input cof_t x);
        logic [COF_W-1:0] u;
        u = x;
        u = x[COF_W-1] ? (~u + 1'b1) : u;
        return u[CMAG_W-1:0];
    endfunction

    function automatic logic [DMAG_W-1:0] det_mag(input det_t x);
        logic [DET_W-1:0] u;
        u = x;
        u = x[DET_W-1] ? (~u + 1'b1) : u;
        return u[DMAG_W-1:0];
    endfunction

    // saturate sign and magnitude to an element, big marks a magnitude beyond QBITS
    function automatic sat_t sat_elem(input logic neg, input logic big,
                                      input logic [QBITS-1:0] mag);
        logic [QBITS-1:0] lim;
        logic [QBITS-1:0] neg_mag;
        sat_t             s;
        lim = {2'b01, {(ELEM_WIDTH-1){1'b0}}};
        neg_mag = ~mag + 1'b1;
        if (neg) begin
            if (big || mag > lim) begin
                s.clip = 1'b1;
                s.val  = {1'b1, {(ELEM_WIDTH-1){1'b0}}};
            end else begin
                s.clip = 1'b0;
                s.val  = neg_mag[ELEM_WIDTH-1:0];
            end
        end else begin
            if (big || mag >= lim) begin
                s.clip = 1'b1;
                s.val  = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
            end else begin
                s.clip = 1'b0;
                s.val  = mag[ELEM_WIDTH-1:0];
            end
        end
        return s;
    endfunction

endpackage

// ===== design/m3i_front.sv =====
module m3i_front (
    input  logic             aclk,
    input  logic [m3i_pkg::FRONT_STAGES-1:0] en,
    input  m3i_pkg::elem_t   m_in [m3i_pkg::N_ELEM],
    output m3i_pkg::cof_t    cof_out [m3i_pkg::N_ELEM],
    output m3i_pkg::det_t    det_out
);
    import m3i_pkg::*;

    logic signed [PROD_W-1:0] pa_reg [N_ELEM];
    logic signed [PROD_W-1:0] pb_reg [N_ELEM];
    elem_t                    top0_reg [3];
    elem_t                    top1_reg [3];
    cof_t                     cof_reg [FRONT_STAGES-1][N_ELEM];
    logic [PROD_W-1:0]        pl_reg [3];
    logic [PROD_W-1:0]        ph_reg [3];
    logic [2:0]               sgn2_reg;
    logic [2:0]               sgn3_reg;
    logic [DMAG_W-1:0]        tm_reg [3];
    det_t                     ts_reg [3];
    det_t                     d01_reg;
    det_t                     t2_reg;
    det_t                     det_reg;

    genvar g, s;
    generate
        // minor products and cofactors
        for (g = 0; g < N_ELEM; g++) begin : g_cof
            localparam int R  = g / 3;
            localparam int C  = g % 3;
            localparam int R1 = (R == 0) ? 1 : 0;
            localparam int R2 = (R == 2) ? 1 : 2;
            localparam int C1 = (C == 0) ? 1 : 0;
            localparam int C2 = (C == 2) ? 1 : 2;
            localparam bit ODD = ((R + C) % 2) == 1;

            always_ff @(posedge aclk) begin
                if (en[0]) begin
                    pa_reg[g] <= m_in[R1*3+C1] * m_in[R2*3+C2];
                    pb_reg[g] <= m_in[R1*3+C2] * m_in[R2*3+C1];
                end
                if (en[1]) begin
                    if (ODD) begin
                        cof_reg[0][g] <= COF_W'(pb_reg[g]) - COF_W'(pa_reg[g]);
                    end else begin
                        cof_reg[0][g] <= COF_W'(pa_reg[g]) - COF_W'(pb_reg[g]);
                    end
                end
            end

            for (s = 1; s < FRONT_STAGES - 1; s++) begin : g_carry
                always_ff @(posedge aclk) begin
                    if (en[s+1]) begin
                        cof_reg[s][g] <= cof_reg[s-1][g];
                    end
                end
            end

            assign cof_out[g] = cof_reg[FRONT_STAGES-2][g];
        end

        // first-row expansion, split into half-width partial products
        for (g = 0; g < 3; g++) begin : g_det
            logic [ELEM_WIDTH-1:0] a_mag;
            logic [CMAG_W-1:0]     c_mag;
            logic [DET_W-1:0]      tm_x;
            assign a_mag = elem_mag(top1_reg[g]);
            assign c_mag = cof_mag(cof_reg[0][g]);
            assign tm_x  = DET_W'(tm_reg[g]);

            always_ff @(posedge aclk) begin
                if (en[0]) begin
                    top0_reg[g] <= m_in[g];
                end
                if (en[1]) begin
                    top1_reg[g] <= top0_reg[g];
                end
                if (en[2]) begin
                    pl_reg[g]   <= a_mag * c_mag[ELEM_WIDTH-1:0];
                    ph_reg[g]   <= a_mag * c_mag[CMAG_W-1:ELEM_WIDTH];
                    sgn2_reg[g] <= top1_reg[g][ELEM_WIDTH-1] ^ cof_reg[0][g][COF_W-1];
                end
                if (en[3]) begin
                    tm_reg[g]   <= {ph_reg[g], {ELEM_WIDTH{1'b0}}} + DMAG_W'(pl_reg[g]);
                    sgn3_reg[g] <= sgn2_reg[g];
                end
                if (en[4]) begin
                    ts_reg[g] <= sgn3_reg[g] ? (~tm_x + 1'b1) : tm_x;
                end
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            d01_reg <= ts_reg[0] + ts_reg[1];
            t2_reg  <= ts_reg[2];
        end
        if (en[6]) begin
            det_reg <= d01_reg + t2_reg;
        end
    end

    assign det_out = det_reg;

endmodule

// ===== design/m3i_div_lane.sv =====
module m3i_div_lane (
    input  logic                 aclk,
    input  logic [m3i_pkg::LANE_STAGES-1:0] en,
    input  m3i_pkg::cof_t        cof_in,
    input  m3i_pkg::det_t        det_in,
    output m3i_pkg::lane_res_t   res
);
    import m3i_pkg::*;

    logic [DMAG_W-1:0] d_reg   [LANE_STAGES];
    logic [DMAG_W-1:0] rem_reg [LANE_STAGES];
    logic [QBITS-1:0]  low_reg [LANE_STAGES];
    logic [QBITS-1:0]  quo_reg [LANE_STAGES];
    logic              neg_reg [LANE_STAGES];
    logic              ovf_reg [LANE_STAGES];

    logic [CMAG_W-1:0] n_mag;
    logic [DMAG_W-1:0] d_mag;
    logic [NUM_W-1:0]  num;
    logic [HI_W-1:0]   hi;
    logic [CMP_W-1:0]  hi_x;

    assign n_mag = cof_mag(cof_in);
    assign d_mag = det_mag(det_in);
    assign num   = {n_mag, {(2*FRAC_BITS){1'b0}}};
    assign hi    = num[NUM_W-1:QBITS];
    assign hi_x  = CMP_W'(hi);

    // quotient beyond QBITS bits is flagged here and never formed
    always_ff @(posedge aclk) begin
        if (en[0]) begin
            d_reg[0]   <= d_mag;
            rem_reg[0] <= hi_x[DMAG_W-1:0];
            low_reg[0] <= num[QBITS-1:0];
            quo_reg[0] <= '0;
            neg_reg[0] <= cof_in[COF_W-1] ^ det_in[DET_W-1];
            ovf_reg[0] <= hi_x >= CMP_W'(d_mag);
        end
    end

    genvar k;
    generate
        for (k = 1; k < LANE_STAGES; k++) begin : g_step
            logic [DMAG_W:0] t;
            logic [DMAG_W:0] diff;
            logic            ge;
            assign t    = {rem_reg[k-1], low_reg[k-1][QBITS-1]};
            assign ge   = t >= {1'b0, d_reg[k-1]};
            assign diff = t - {1'b0, d_reg[k-1]};

            always_ff @(posedge aclk) begin
                if (en[k]) begin
                    rem_reg[k] <= ge ? diff[DMAG_W-1:0] : t[DMAG_W-1:0];
                    low_reg[k] <= {low_reg[k-1][QBITS-2:0], 1'b0};
                    quo_reg[k] <= {quo_reg[k-1][QBITS-2:0], ge};
                    d_reg[k]   <= d_reg[k-1];
                    neg_reg[k] <= neg_reg[k-1];
                    ovf_reg[k] <= ovf_reg[k-1];
                end
            end
        end
    endgenerate

    assign res.neg = neg_reg[LANE_STAGES-1];
    assign res.ovf = ovf_reg[LANE_STAGES-1];
    assign res.quo = quo_reg[LANE_STAGES-1];

endmodule

// ===== design/matrix3x3_inverse.sv =====
// 3x3 matrix inverse by adjugate over determinant, signed Q16.16 in and out. Every
// intermediate value is exact: cofactors are formed from 32x32 products, the determinant
// is expanded along the first row, and nine division lanes, one per inverse element,
// each produce a 33-bit quotient one bit per stage with a flag for larger quotients. The
// determinant is saturated at the lane set-up stage; a merging stage saturates the nine
// quotients, raises clipped on any saturation and forces all-zero elements when the
// determinant is zero. An accepted word passes 7 cofactor and determinant stages, a lane
// set-up stage, 33 restoring-division stages and one merging stage; one word enters per
// cycle while m_ready does not hold the output. Any stage that holds no word takes the
// next one, so input keeps flowing into empty stages while a result waits on m_ready.
module matrix3x3_inverse (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  m3i_pkg::elem_t s_m00,
    input  m3i_pkg::elem_t s_m01,
    input  m3i_pkg::elem_t s_m02,
    input  m3i_pkg::elem_t s_m10,
    input  m3i_pkg::elem_t s_m11,
    input  m3i_pkg::elem_t s_m12,
    input  m3i_pkg::elem_t s_m20,
    input  m3i_pkg::elem_t s_m21,
    input  m3i_pkg::elem_t s_m22,
    output logic           m_valid,
    input  logic           m_ready,
    output m3i_pkg::elem_t m_r00,
    output m3i_pkg::elem_t m_r01,
    output m3i_pkg::elem_t m_r02,
    output m3i_pkg::elem_t m_r10,
    output m3i_pkg::elem_t m_r11,
    output m3i_pkg::elem_t m_r12,
    output m3i_pkg::elem_t m_r20,
    output m3i_pkg::elem_t m_r21,
    output m3i_pkg::elem_t m_r22,
    output m3i_pkg::elem_t m_det_out,
    output logic           m_singular,
    output logic           m_clipped
);
    import m3i_pkg::*;

    // determinant side information travelling beside the division lanes
    typedef struct packed {
        logic  sing;
        logic  dclip;
        elem_t dval;
    } meta_t;

    localparam int MERGE = PIPE_STAGES - 1;

    logic [PIPE_STAGES-1:0] vld_reg;
    logic [PIPE_STAGES-1:0] rdy;

    elem_t     m_in [N_ELEM];
    cof_t      cof  [N_ELEM];
    det_t      det;
    lane_res_t lres [N_ELEM];
    meta_t     meta_reg [LANE_STAGES];
    meta_t     meta_next;

    elem_t r_reg [N_ELEM];
    elem_t det_reg;
    logic  sing_reg;
    logic  clip_reg;

    assign m_in[0] = s_m00;
    assign m_in[1] = s_m01;
    assign m_in[2] = s_m02;
    assign m_in[3] = s_m10;
    assign m_in[4] = s_m11;
    assign m_in[5] = s_m12;
    assign m_in[6] = s_m20;
    assign m_in[7] = s_m21;
    assign m_in[8] = s_m22;

    // a stage may load when it is empty or its word moves on
    assign rdy[MERGE] = !vld_reg[MERGE] || m_ready;

    genvar k;
    generate
        for (k = 0; k < MERGE; k++) begin : g_rdy
            assign rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (rdy[0]) begin
                vld_reg[0] <= s_valid;
            end
            for (int i = 1; i < PIPE_STAGES; i++) begin
                if (rdy[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    assign s_ready = rdy[0];

    // cofactors and determinant
    m3i_front u_front (
        .aclk    (aclk),
        .en      (rdy[FRONT_STAGES-1:0]),
        .m_in    (m_in),
        .cof_out (cof),
        .det_out (det)
    );

    // one division lane per inverse element, lane r*3+c divides cofactor (c, r)
    generate
        for (k = 0; k < N_ELEM; k++) begin : g_lane
            m3i_div_lane u_lane (
                .aclk   (aclk),
                .en     (rdy[FRONT_STAGES+LANE_STAGES-1:FRONT_STAGES]),
                .cof_in (cof[(k % 3) * 3 + (k / 3)]),
                .det_in (det),
                .res    (lres[k])
            );
        end
    endgenerate

    // determinant shifted down by the fraction bits of the squared scale, then saturated
    logic [DMAG_W-1:0] dm;
    logic [DMAG_W-1:0] dsh;
    sat_t              dsat;

    always_comb begin
        dm   = det_mag(det);
        dsh  = dm >> (2 * FRAC_BITS);
        dsat = sat_elem(det[DET_W-1], |dsh[DMAG_W-1:QBITS], dsh[QBITS-1:0]);
        meta_next.sing  = (det == '0);
        meta_next.dclip = meta_next.sing ? 1'b0 : dsat.clip;
        meta_next.dval  = meta_next.sing ? '0 : dsat.val;
    end

    always_ff @(posedge aclk) begin
        if (rdy[FRONT_STAGES]) begin
            meta_reg[0] <= meta_next;
        end
        for (int i = 1; i < LANE_STAGES; i++) begin
            if (rdy[FRONT_STAGES+i]) begin
                meta_reg[i] <= meta_reg[i-1];
            end
        end
    end

    // merging stage: saturate the lanes and gather the flags
    sat_t  lsat [N_ELEM];
    logic  any_clip;
    meta_t mt;

    always_comb begin
        mt       = meta_reg[LANE_STAGES-1];
        any_clip = mt.dclip;
        for (int i = 0; i < N_ELEM; i++) begin
            lsat[i]  = sat_elem(lres[i].neg, lres[i].ovf, lres[i].quo);
            any_clip = any_clip | lsat[i].clip;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[MERGE]) begin
            for (int i = 0; i < N_ELEM; i++) begin
                r_reg[i] <= mt.sing ? '0 : lsat[i].val;
            end
            det_reg  <= mt.dval;
            sing_reg <= mt.sing;
            clip_reg <= mt.sing ? 1'b0 : any_clip;
        end
    end

    assign m_valid    = vld_reg[MERGE];
    assign m_r00      = r_reg[0];
    assign m_r01      = r_reg[1];
    assign m_r02      = r_reg[2];
    assign m_r10      = r_reg[3];
    assign m_r11      = r_reg[4];
    assign m_r12      = r_reg[5];
    assign m_r20      = r_reg[6];
    assign m_r21      = r_reg[7];
    assign m_r22      = r_reg[8];
    assign m_det_out  = det_reg;
    assign m_singular = sing_reg;
    assign m_clipped  = clip_reg;

    // a singular result is never clipped and has zero diagonal elements and determinant
    a_singular_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_singular |-> !m_clipped && m_det_out == '0 && m_r00 == '0
            && m_r11 == '0 && m_r22 == '0)
        else $error("singular result not cleared");

    // an accepted word lands in the first stage
    a_accept_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> vld_reg[0])
        else $error("accepted word lost at pipeline entry");

    // a waiting result leaves the stage before it free to fill
    a_skid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready && !vld_reg[MERGE-1] |-> rdy[MERGE-1])
        else $error("stage ahead of output blocked while empty");

endmodule
